>>> rtl/afq_pkg.sv
`default_nettype none
package afq_pkg;

    // default geometry
    localparam int AFQ_DEPTH      = 32;
    localparam int AFQ_FRAME_BITS = 16;
    localparam int AFQ_NODE_BITS  = 8;
    localparam int AFQ_AGE_BITS   = 16;

    // fixed field widths
    localparam int MAXLEN_W   = 6;
    localparam int DROP_W     = 32;
    localparam int STATUS_W   = 2;
    localparam int CMD_W      = 2;

    localparam logic [MAXLEN_W-1:0] MAXLEN_RESET = 6'd32;

    // commands
    localparam logic [CMD_W-1:0] CMD_APPEND     = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TICK       = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE_NODE = 2'd2;
    localparam logic [CMD_W-1:0] CMD_REMOVE_ALL = 2'd3;

    // result status
    localparam logic [STATUS_W-1:0] ST_APPENDED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DROPPED  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_REMOVED  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NONE     = 2'd3;

    // per-cell control
    typedef struct packed {
        logic shift;    // take neighbor's entry
        logic load;     // take entry from write bus
        logic age_set;  // overwrite age (wins over the other two)
    } afq_cell_ctl_t;

endpackage
`default_nettype wire

>>> rtl/age_limited_frame_queue.sv
`default_nettype none
// Channel | Dir | Handshake             | Words
// in      | in  | in_valid / in_ready   | command, frame_handle, node_id, max_age, quanta
// out     | out | out_valid / out_ready | status, out_frame, out_node, last, drops_so_far
// cfg     | in  | cfg_valid / cfg_ready | cfg_data (max_length)
//
// An append is handled in its accept cycle. An age tick pops expired frames from the head one
// at a time after the accept cycle, then ages the head. A remove examines each queued entry in
// turn: the chain rotates once through the head, where entries are examined.
// Results leave through one output register; the sequencer stalls while it is full.
// Reset empties the queue and clears the drop count; no clearing pass.
module age_limited_frame_queue
    import afq_pkg::*;
#(
    parameter int QUEUE_DEPTH = AFQ_DEPTH,
    parameter int FRAME_BITS  = AFQ_FRAME_BITS,
    parameter int NODE_BITS   = AFQ_NODE_BITS,
    parameter int AGE_BITS    = AFQ_AGE_BITS
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [CMD_W-1:0]      command,
    input  wire logic [FRAME_BITS-1:0] frame_handle,
    input  wire logic [NODE_BITS-1:0]  node_id,
    input  wire logic [AGE_BITS-1:0]   max_age,
    input  wire logic [AGE_BITS-1:0]   quanta,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic      [STATUS_W-1:0]   status,
    output logic      [FRAME_BITS-1:0] out_frame,
    output logic      [NODE_BITS-1:0]  out_node,
    output logic                       last,
    output logic      [DROP_W-1:0]     drops_so_far,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [MAXLEN_W-1:0]   cfg_data
);

    localparam int LEN_W = $clog2(QUEUE_DEPTH + 1);
    localparam int IDX_W = $clog2(QUEUE_DEPTH);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_TICK = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;

    logic [1:0]            state_reg, state_next;
    logic [LEN_W-1:0]      len_reg, len_next;
    logic [LEN_W-1:0]      r_reg, r_next;
    logic [LEN_W-1:0]      k_reg, k_next;
    logic                  first_reg, first_next;
    logic                  gone_reg, gone_next;
    logic                  any_reg, any_next;
    logic                  all_reg, all_next;
    logic [NODE_BITS-1:0]  nodeq_reg, nodeq_next;
    logic [AGE_BITS-1:0]   qq_reg, qq_next;
    logic [AGE_BITS-1:0]   hage_reg, hage_next;
    logic [MAXLEN_W-1:0]   maxlen_reg;
    logic [DROP_W-1:0]     drops_reg, drops_next;

    logic                  ov_reg;
    logic [STATUS_W-1:0]   st_reg;
    logic [FRAME_BITS-1:0] of_reg;
    logic [NODE_BITS-1:0]  on_reg;
    logic                  last_reg;

    // cell chain
    logic [FRAME_BITS-1:0] c_frame [QUEUE_DEPTH];
    logic [NODE_BITS-1:0]  c_node  [QUEUE_DEPTH];
    logic [AGE_BITS-1:0]   c_age   [QUEUE_DEPTH];
    afq_cell_ctl_t         c_ctl   [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] match;

    logic                  shift;
    logic                  wr_en;
    logic [IDX_W-1:0]      wr_idx;
    logic [FRAME_BITS-1:0] wr_frame;
    logic [NODE_BITS-1:0]  wr_node;
    logic [AGE_BITS-1:0]   wr_age;
    logic                  set0;
    logic [AGE_BITS-1:0]   set_age;

    logic                  emit;
    logic [STATUS_W-1:0]   e_status;
    logic [FRAME_BITS-1:0] e_frame;
    logic [NODE_BITS-1:0]  e_node;
    logic                  e_last;

    logic                  slot_free;
    logic                  full;
    logic                  pop;
    logic                  more;
    logic                  hit;
    logic                  later;
    logic [LEN_W-1:0]      knew;

    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++)
        begin : g_cell
            localparam int NB = (gi == QUEUE_DEPTH - 1) ? gi : gi + 1;

            always_comb
            begin
                c_ctl[gi].shift   = shift;
                c_ctl[gi].load    = wr_en && (wr_idx == IDX_W'(gi));
                c_ctl[gi].age_set = set0 && (gi == 0);
            end

            // entry still unexamined and owned by the node (or any node)
            assign match[gi] = (LEN_W'(gi) < r_reg) && (all_reg || (c_node[gi] == nodeq_reg));

            afq_cell #(
                .FRAME_BITS (FRAME_BITS),
                .NODE_BITS  (NODE_BITS),
                .AGE_BITS   (AGE_BITS)
            ) u_cell (
                .clk      (clk),
                .ctl      (c_ctl[gi]),
                .nb_frame (c_frame[NB]),
                .nb_node  (c_node[NB]),
                .nb_age   (c_age[NB]),
                .wr_frame (wr_frame),
                .wr_node  (wr_node),
                .wr_age   (wr_age),
                .set_age  (set_age),
                .frame    (c_frame[gi]),
                .node     (c_node[gi]),
                .age      (c_age[gi])
            );
        end
    endgenerate

    assign slot_free = !ov_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE) && slot_free;
    assign cfg_ready = 1'b1;

    // limit check; a limit above the depth acts as the depth
    always_comb
    begin
        if (32'(maxlen_reg) >= 32'(QUEUE_DEPTH))
            full = (32'(len_reg) >= 32'(QUEUE_DEPTH));
        else
            full = (32'(len_reg) >= 32'(maxlen_reg));
    end

    assign pop   = (len_reg != '0) && (c_age[0] < qq_reg);
    assign more  = (len_reg > LEN_W'(1)) && (c_age[1] < qq_reg);
    assign hit   = match[0];
    assign later = |match[QUEUE_DEPTH-1:1];
    assign knew  = hit ? k_reg : k_reg + LEN_W'(1);

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        len_next   = len_reg;
        r_next     = r_reg;
        k_next     = k_reg;
        first_next = first_reg;
        gone_next  = gone_reg;
        any_next   = any_reg;
        all_next   = all_reg;
        nodeq_next = nodeq_reg;
        qq_next    = qq_reg;
        hage_next  = hage_reg;
        drops_next = drops_reg;

        shift    = 1'b0;
        wr_en    = 1'b0;
        wr_idx   = len_reg[IDX_W-1:0];
        wr_frame = frame_handle;
        wr_node  = node_id;
        wr_age   = (len_reg == '0) ? max_age
                 : ((max_age > c_age[0]) ? max_age - c_age[0] : '0);
        set0     = 1'b0;
        set_age  = c_age[0] - qq_reg;

        emit     = 1'b0;
        e_status = ST_NONE;
        e_frame  = '0;
        e_node   = '0;
        e_last   = 1'b1;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    case (command)
                        CMD_APPEND:
                        begin
                            emit = 1'b1;
                            if (full)
                            begin
                                drops_next = drops_reg + DROP_W'(1);
                                e_status   = ST_DROPPED;
                                e_frame    = frame_handle;
                                e_node     = node_id;
                            end
                            else
                            begin
                                wr_en    = 1'b1;
                                len_next = len_reg + LEN_W'(1);
                                e_status = ST_APPENDED;
                            end
                        end
                        CMD_TICK:
                        begin
                            qq_next    = quanta;
                            state_next = S_TICK;
                        end
                        default:
                        begin
                            nodeq_next = node_id;
                            all_next   = (command == CMD_REMOVE_ALL);
                            r_next     = len_reg;
                            k_next     = '0;
                            first_next = 1'b1;
                            gone_next  = 1'b0;
                            any_next   = 1'b0;
                            hage_next  = c_age[0];
                            state_next = S_SCAN;
                        end
                    endcase
                end
            end

            S_TICK:
            begin
                if (slot_free)
                begin
                    emit = 1'b1;
                    if (pop)
                    begin
                        e_status = ST_REMOVED;
                        e_frame  = c_frame[0];
                        e_node   = c_node[0];
                        e_last   = !more;
                        shift    = 1'b1;
                        len_next = len_reg - LEN_W'(1);
                        if (!more)
                        begin
                            // age the entry that becomes the head
                            set0       = (len_reg > LEN_W'(1));
                            set_age    = c_age[1] - qq_reg;
                            state_next = S_IDLE;
                        end
                    end
                    else
                    begin
                        set0       = (len_reg != '0);
                        state_next = S_IDLE;
                    end
                end
            end

            S_SCAN:
            begin
                if (slot_free)
                begin
                    if (r_reg == '0)
                    begin
                        emit       = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        // head leaves; kept entries are re-inserted behind the rest
                        shift      = 1'b1;
                        r_next     = r_reg - LEN_W'(1);
                        first_next = 1'b0;
                        k_next     = knew;
                        wr_frame   = c_frame[0];
                        wr_node    = c_node[0];
                        wr_age     = c_age[0];
                        wr_idx     = IDX_W'(r_reg + k_reg - LEN_W'(1));
                        if (hit)
                        begin
                            emit      = 1'b1;
                            e_status  = ST_REMOVED;
                            e_frame   = c_frame[0];
                            e_node    = c_node[0];
                            e_last    = !later;
                            any_next  = 1'b1;
                            gone_next = gone_reg || first_reg;
                        end
                        else
                        begin
                            wr_en = 1'b1;
                        end

                        if (r_reg == LEN_W'(1))
                        begin
                            len_next   = knew;
                            state_next = S_IDLE;
                            set0       = (gone_reg || (first_reg && hit)) && (knew != '0);
                            set_age    = hage_reg;
                            if (!any_reg && !hit)
                                emit = 1'b1;
                        end
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            len_reg    <= '0;
            r_reg      <= '0;
            k_reg      <= '0;
            first_reg  <= 1'b0;
            gone_reg   <= 1'b0;
            any_reg    <= 1'b0;
            all_reg    <= 1'b0;
            drops_reg  <= '0;
            maxlen_reg <= MAXLEN_RESET;
            ov_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            len_reg   <= len_next;
            r_reg     <= r_next;
            k_reg     <= k_next;
            first_reg <= first_next;
            gone_reg  <= gone_next;
            any_reg   <= any_next;
            all_reg   <= all_next;
            drops_reg <= drops_next;
            if (cfg_valid && cfg_ready)
                maxlen_reg <= cfg_data;
            if (emit)
                ov_reg <= 1'b1;
            else if (out_ready)
                ov_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        nodeq_reg <= nodeq_next;
        qq_reg    <= qq_next;
        hage_reg  <= hage_next;
        if (emit)
        begin
            st_reg   <= e_status;
            of_reg   <= e_frame;
            on_reg   <= e_node;
            last_reg <= e_last;
        end
    end

    assign out_valid    = ov_reg;
    assign status       = st_reg;
    assign out_frame    = of_reg;
    assign out_node     = on_reg;
    assign last         = last_reg;
    assign drops_so_far = drops_reg;

    // checks
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(len_reg) <= 32'(QUEUE_DEPTH))
        else $error("queue length above depth");

    a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !in_ready)
        else $error("input ready while busy");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (32'(r_reg) + 32'(k_reg) <= 32'(QUEUE_DEPTH)))
        else $error("scan counters exceed depth");

    a_no_emit_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && !out_ready) |=> $stable(st_reg) && $stable(of_reg))
        else $error("held result overwritten");

endmodule
`default_nettype wire

>>> rtl/afq_cell.sv
`default_nettype none
module afq_cell
    import afq_pkg::*;
#(
    parameter int FRAME_BITS = AFQ_FRAME_BITS,
    parameter int NODE_BITS  = AFQ_NODE_BITS,
    parameter int AGE_BITS   = AFQ_AGE_BITS
)
(
    input  wire logic                  clk,
    input  wire afq_cell_ctl_t         ctl,
    input  wire logic [FRAME_BITS-1:0] nb_frame,
    input  wire logic [NODE_BITS-1:0]  nb_node,
    input  wire logic [AGE_BITS-1:0]   nb_age,
    input  wire logic [FRAME_BITS-1:0] wr_frame,
    input  wire logic [NODE_BITS-1:0]  wr_node,
    input  wire logic [AGE_BITS-1:0]   wr_age,
    input  wire logic [AGE_BITS-1:0]   set_age,
    output logic      [FRAME_BITS-1:0] frame,
    output logic      [NODE_BITS-1:0]  node,
    output logic      [AGE_BITS-1:0]   age
);

    logic [FRAME_BITS-1:0] frame_reg;
    logic [NODE_BITS-1:0]  node_reg;
    logic [AGE_BITS-1:0]   age_reg;

    // entry payload, no reset
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            frame_reg <= wr_frame;
            node_reg  <= wr_node;
        end
        else if (ctl.shift)
        begin
            frame_reg <= nb_frame;
            node_reg  <= nb_node;
        end

        if (ctl.age_set)
            age_reg <= set_age;
        else if (ctl.load)
            age_reg <= wr_age;
        else if (ctl.shift)
            age_reg <= nb_age;
    end

    assign frame = frame_reg;
    assign node  = node_reg;
    assign age   = age_reg;

endmodule
`default_nettype wire
